### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

### hw/rtl/sdspi_pkg.sv
// Shared types and constants for the SD card SPI host sequencer
package sdspi_pkg;

    localparam int unsigned SectorBytes = 512;
    localparam int unsigned DummyBytes  = 10;

    typedef enum logic [3:0] {
        PH_IDLE, PH_DUMMY, PH_SEND, PH_R1, PH_REST, PH_END, PH_TOKEN,
        PH_RDATA, PH_RCRC, PH_WTOKEN, PH_WNEED, PH_WDATA, PH_WCRC,
        PH_DRESP, PH_BUSY
    } phase_t;

    typedef enum logic [3:0] {
        ST_CMD0, ST_CMD8, ST_OCR1, ST_CMD55, ST_ACMD41, ST_OCR2, ST_CMD16,
        ST_CMD17, ST_CMD24, ST_CMD13
    } stage_t;

    typedef enum logic [2:0] {
        KIND_INIT  = 3'd0,
        KIND_READ  = 3'd1,
        KIND_WRITE = 3'd2,
        KIND_CARD  = 3'd3,
        KIND_WDATA = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        STS_OK        = 4'd0,
        STS_CMD0      = 4'd1,
        STS_CMD8_V1   = 4'd2,
        STS_CMD8_BAD  = 4'd3,
        STS_OCR1      = 4'd4,
        STS_CMD55     = 4'd5,
        STS_ACMD41    = 4'd6,
        STS_OCR2      = 4'd7,
        STS_CMD16     = 4'd8,
        STS_CMD17     = 4'd9,
        STS_TOKEN     = 4'd10,
        STS_CMD24     = 4'd11,
        STS_DRESP     = 4'd12,
        STS_BUSY      = 4'd13,
        STS_CMD13     = 4'd14,
        STS_BUSY_REQ  = 4'd15
    } status_t;

    typedef enum logic [2:0] {
        CFG_R1_POLL, CFG_CMD_RETRY, CFG_APP_RETRY, CFG_TOKEN_WAIT,
        CFG_DRESP_WAIT, CFG_BUSY_WAIT
    } cfg_idx_t;

    typedef struct packed {
        logic       transfer_valid;
        logic [7:0] transfer_byte;
        logic       select_card;
        logic       sector_byte_valid;
        logic [7:0] sector_byte;
        logic       want_write_byte;
        logic       done_res;
        logic [3:0] status;
        logic       card_is_standard_out;
    } result_t;

    // Command frame byte for a stage; idx 0 is the command, 1..4 argument, 5 CRC
    function automatic logic [7:0] frame_byte(stage_t st, logic [2:0] idx,
                                              logic [31:0] addr);
        logic [31:0] arg;
        logic [7:0]  crc;
        logic [5:0]  cmd;
        arg = 32'h0;
        crc = 8'h00;
        unique case (st)
            ST_CMD0:   begin cmd = 6'd0;  crc = 8'h95; end
            ST_CMD8:   begin cmd = 6'd8;  arg = 32'h0000_01AA; crc = 8'h87; end
            ST_OCR1:   cmd = 6'd58;
            ST_CMD55:  cmd = 6'd55;
            ST_ACMD41: begin cmd = 6'd41; arg = 32'h4000_0000; end
            ST_OCR2:   cmd = 6'd58;
            ST_CMD16:  begin cmd = 6'd16; arg = 32'(SectorBytes); end
            ST_CMD17:  begin cmd = 6'd17; arg = addr; end
            ST_CMD24:  begin cmd = 6'd24; arg = addr; end
            ST_CMD13:  cmd = 6'd13;
            default:   cmd = 6'd0;
        endcase
        unique case (idx)
            3'd0:    frame_byte = {2'b01, cmd};
            3'd1:    frame_byte = arg[31:24];
            3'd2:    frame_byte = arg[23:16];
            3'd3:    frame_byte = arg[15:8];
            3'd4:    frame_byte = arg[7:0];
            default: frame_byte = crc;
        endcase
    endfunction

endpackage

### hw/rtl/sdspi_cfg_regs.sv
// Configuration register file for the SD card SPI host sequencer
module sdspi_cfg_regs (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    output logic [7:0]  r1_poll_limit,
    output logic [11:0] command_retry_limit,
    output logic [11:0] app_init_retry_limit,
    output logic [23:0] token_wait_limit,
    output logic [11:0] data_response_limit,
    output logic [23:0] busy_wait_limit
);
    logic [7:0]  r1_reg;
    logic [11:0] cmd_reg, app_reg, dresp_reg;
    logic [23:0] tok_reg, busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r1_reg    <= 8'd255;
            cmd_reg   <= 12'd254;
            app_reg   <= 12'd4094;
            tok_reg   <= 24'd16777214;
            dresp_reg <= 12'd4094;
            busy_reg  <= 24'd16777214;
        end else if (cfg_we) begin
            case (cfg_index)
                sdspi_pkg::CFG_R1_POLL:    r1_reg    <= cfg_data[7:0];
                sdspi_pkg::CFG_CMD_RETRY:  cmd_reg   <= cfg_data[11:0];
                sdspi_pkg::CFG_APP_RETRY:  app_reg   <= cfg_data[11:0];
                sdspi_pkg::CFG_TOKEN_WAIT: tok_reg   <= cfg_data;
                sdspi_pkg::CFG_DRESP_WAIT: dresp_reg <= cfg_data[11:0];
                sdspi_pkg::CFG_BUSY_WAIT:  busy_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign r1_poll_limit        = r1_reg;
    assign command_retry_limit  = cmd_reg;
    assign app_init_retry_limit = app_reg;
    assign token_wait_limit     = tok_reg;
    assign data_response_limit  = dresp_reg;
    assign busy_wait_limit      = busy_reg;
endmodule

### hw/rtl/sd_card_spi_host_sequencer.sv
// SD card SPI-mode host sequencer: top level
//
//  channel   | signals                                      | direction
//  s_        | kind, sector, card_byte, write_byte          | in, valid/ready
//  m_        | transfer, sector byte, write request, status | out, valid/ready
//  cfg_      | cfg_we, cfg_index, cfg_data                  | in, write only
//
// One word in, one word out; each word is handled by the FSM step.
// The result sits in an output register; a new word is taken whenever that
// register is empty or being drained, so the rate is one word per cycle.
// Reset is synchronous on aresetn; no clearing pass. A stalled m_ side holds
// s_ready low only while the output register is full and not taken.
module sd_card_spi_host_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_kind,
    input  logic [31:0] s_sector,
    input  logic [7:0]  s_card_byte,
    input  logic [7:0]  s_write_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_transfer_valid,
    output logic [7:0]  m_transfer_byte,
    output logic        m_select_card,
    output logic        m_sector_byte_valid,
    output logic [7:0]  m_sector_byte,
    output logic        m_want_write_byte,
    output logic        m_done_res,
    output logic [3:0]  m_status,
    output logic        m_card_is_standard_out
);
    logic [7:0]  r1_lim;
    logic [11:0] cmd_lim, app_lim, dresp_lim;
    logic [23:0] tok_lim, busy_lim;

    sdspi_cfg_regs u_cfg (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_data,
        .r1_poll_limit(r1_lim), .command_retry_limit(cmd_lim),
        .app_init_retry_limit(app_lim), .token_wait_limit(tok_lim),
        .data_response_limit(dresp_lim), .busy_wait_limit(busy_lim)
    );

    sdspi_pkg::phase_t  phase_reg, phase_next;
    sdspi_pkg::stage_t  stage_reg, stage_next;
    logic               std_reg, std_next;
    logic [11:0]        retry_reg, retry_next;
    logic [23:0]        poll_reg, poll_next;
    logic [9:0]         bcnt_reg, bcnt_next;
    logic [31:0]        addr_reg, addr_next;
    logic [7:0]         r1_reg, r1_next;
    logic [31:0]        resp_reg, resp_next;
    sdspi_pkg::result_t res_reg, res;
    logic               mvalid_reg;

    logic accept;
    assign s_ready = !mvalid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Zero limits act as one
    logic [7:0]  r1_e;
    logic [11:0] cmd_e, app_e, dresp_e;
    logic [23:0] tok_e, busy_e;
    assign r1_e    = (r1_lim == '0) ? 8'd1 : r1_lim;
    assign cmd_e   = (cmd_lim == '0) ? 12'd1 : cmd_lim;
    assign app_e   = (app_lim == '0) ? 12'd1 : app_lim;
    assign dresp_e = (dresp_lim == '0) ? 12'd1 : dresp_lim;
    assign tok_e   = (tok_lim == '0) ? 24'd1 : tok_lim;
    assign busy_e  = (busy_lim == '0) ? 24'd1 : busy_lim;

    logic [11:0] retry_inc;
    logic [23:0] poll_inc;
    logic [9:0]  bcnt_inc;
    logic [2:0]  rest_len;
    assign retry_inc = retry_reg + 12'd1;
    assign poll_inc  = poll_reg + 24'd1;
    assign bcnt_inc  = bcnt_reg + 10'd1;
    always_comb begin
        unique case (stage_reg)
            sdspi_pkg::ST_CMD8, sdspi_pkg::ST_OCR1, sdspi_pkg::ST_OCR2: rest_len = 3'd4;
            sdspi_pkg::ST_CMD13: rest_len = 3'd1;
            default: rest_len = 3'd0;
        endcase
    end

    always_comb begin
        logic [7:0]         r;
        sdspi_pkg::stage_t  nst;
        logic               do_start;
        logic               do_fin;
        logic [3:0]         fcode;
        logic               do_after_r1;
        logic               do_retry;
        logic [11:0]        rlim;
        logic [3:0]         rcode;
        sdspi_pkg::stage_t  rst_st;
        r           = r1_reg;
        nst         = stage_reg;
        do_start    = 1'b0;
        do_fin      = 1'b0;
        fcode       = sdspi_pkg::STS_OK;
        do_after_r1 = 1'b0;
        do_retry    = 1'b0;
        rlim        = cmd_e;
        rcode       = sdspi_pkg::STS_OK;
        rst_st      = stage_reg;

        phase_next = phase_reg;
        stage_next = stage_reg;
        std_next   = std_reg;
        retry_next = retry_reg;
        poll_next  = poll_reg;
        bcnt_next  = bcnt_reg;
        addr_next  = addr_reg;
        r1_next    = r1_reg;
        resp_next  = resp_reg;
        res        = '0;

        if (s_kind <= sdspi_pkg::KIND_WRITE) begin
            if (phase_reg != sdspi_pkg::PH_IDLE) begin
                res.done_res = 1'b1;
                res.status   = sdspi_pkg::STS_BUSY_REQ;
            end else if (s_kind == sdspi_pkg::KIND_INIT) begin
                retry_next = '0;
                bcnt_next  = '0;
                phase_next = sdspi_pkg::PH_DUMMY;
                res.transfer_valid = 1'b1;
                res.transfer_byte  = 8'hFF;
            end else begin
                addr_next = std_reg ? {s_sector[22:0], 9'd0} : s_sector;
                do_start  = 1'b1;
                nst = (s_kind == sdspi_pkg::KIND_READ) ? sdspi_pkg::ST_CMD17
                                                       : sdspi_pkg::ST_CMD24;
            end
        end else if (s_kind == sdspi_pkg::KIND_CARD) begin
            unique case (phase_reg)
                sdspi_pkg::PH_DUMMY: begin
                    bcnt_next = bcnt_inc;
                    if (bcnt_inc < 10'(sdspi_pkg::DummyBytes)) begin
                        res.transfer_valid = 1'b1;
                        res.transfer_byte  = 8'hFF;
                    end else begin
                        retry_next = '0;
                        do_start = 1'b1;
                        nst = sdspi_pkg::ST_CMD0;
                    end
                end
                sdspi_pkg::PH_SEND: begin
                    bcnt_next = bcnt_inc;
                    res.transfer_valid = 1'b1;
                    res.select_card    = 1'b1;
                    if (bcnt_inc < 10'd6) begin
                        res.transfer_byte = sdspi_pkg::frame_byte(stage_reg,
                                                bcnt_inc[2:0], addr_reg);
                    end else begin
                        poll_next  = '0;
                        phase_next = sdspi_pkg::PH_R1;
                        res.transfer_byte = 8'hFF;
                    end
                end
                sdspi_pkg::PH_R1: begin
                    if (s_card_byte != 8'hFF) begin
                        r = s_card_byte;
                        r1_next = r;
                        do_after_r1 = 1'b1;
                    end else begin
                        poll_next = poll_inc;
                        if (poll_inc >= {16'd0, r1_e}) begin
                            r = 8'hFF;
                            r1_next = r;
                            do_after_r1 = 1'b1;
                        end else begin
                            res.transfer_valid = 1'b1;
                            res.transfer_byte  = 8'hFF;
                            res.select_card    = 1'b1;
                        end
                    end
                end
                sdspi_pkg::PH_REST: begin
                    resp_next = {resp_reg[23:0], s_card_byte};
                    bcnt_next = bcnt_inc;
                    res.transfer_valid = 1'b1;
                    res.transfer_byte  = 8'hFF;
                    if (bcnt_inc < {7'd0, rest_len}) res.select_card = 1'b1;
                    else phase_next = sdspi_pkg::PH_END;
                end
                sdspi_pkg::PH_END: begin
                    unique case (stage_reg)
                        sdspi_pkg::ST_CMD0: begin
                            if (r == 8'h01) begin
                                retry_next = '0; do_start = 1'b1; nst = sdspi_pkg::ST_CMD8;
                            end else begin
                                do_retry = 1'b1; rcode = sdspi_pkg::STS_CMD0;
                                rst_st = sdspi_pkg::ST_CMD0;
                            end
                        end
                        sdspi_pkg::ST_CMD8: begin
                            if (r == 8'h09) begin
                                do_fin = 1'b1; fcode = sdspi_pkg::STS_CMD8_V1;
                            end else if (r == 8'h01 && resp_reg[11:8] == 4'h1 &&
                                         resp_reg[7:0] == 8'hAA) begin
                                retry_next = '0; do_start = 1'b1; nst = sdspi_pkg::ST_OCR1;
                            end else begin
                                do_fin = 1'b1; fcode = sdspi_pkg::STS_CMD8_BAD;
                            end
                        end
                        sdspi_pkg::ST_OCR1: begin
                            if (r == 8'h01 && resp_reg[20:16] != 5'd0 && resp_reg[15]) begin
                                retry_next = '0; do_start = 1'b1; nst = sdspi_pkg::ST_CMD55;
                            end else begin
                                do_retry = 1'b1; rcode = sdspi_pkg::STS_OCR1;
                                rst_st = sdspi_pkg::ST_OCR1;
                            end
                        end
                        sdspi_pkg::ST_CMD55: begin
                            if (r != 8'h01) begin
                                do_fin = 1'b1; fcode = sdspi_pkg::STS_CMD55;
                            end else begin
                                do_start = 1'b1; nst = sdspi_pkg::ST_ACMD41;
                            end
                        end
                        sdspi_pkg::ST_ACMD41: begin
                            if (r == 8'h00) begin
                                retry_next = '0; do_start = 1'b1; nst = sdspi_pkg::ST_OCR2;
                            end else begin
                                do_retry = 1'b1; rlim = app_e; rcode = sdspi_pkg::STS_ACMD41;
                                rst_st = sdspi_pkg::ST_CMD55;
                            end
                        end
                        sdspi_pkg::ST_OCR2: begin
                            if (r == 8'h00) begin
                                if (resp_reg[30]) begin
                                    std_next = 1'b0; do_fin = 1'b1;
                                end else begin
                                    retry_next = '0; do_start = 1'b1;
                                    nst = sdspi_pkg::ST_CMD16;
                                end
                            end else begin
                                do_retry = 1'b1; rcode = sdspi_pkg::STS_OCR2;
                                rst_st = sdspi_pkg::ST_OCR2;
                            end
                        end
                        sdspi_pkg::ST_CMD16: begin
                            if (r == 8'h00) begin
                                std_next = 1'b1; do_fin = 1'b1;
                            end else begin
                                do_retry = 1'b1; rcode = sdspi_pkg::STS_CMD16;
                                rst_st = sdspi_pkg::ST_CMD16;
                            end
                        end
                        sdspi_pkg::ST_CMD24: begin
                            do_start = 1'b1; nst = sdspi_pkg::ST_CMD13;
                        end
                        sdspi_pkg::ST_CMD13: begin
                            do_fin = 1'b1;
                            fcode = (r == 8'h00 && resp_reg[7:0] == 8'h00)
                                    ? sdspi_pkg::STS_OK : sdspi_pkg::STS_CMD13;
                        end
                        default: do_fin = 1'b1;
                    endcase
                end
                sdspi_pkg::PH_TOKEN: begin
                    res.transfer_byte = 8'hFF;
                    if (s_card_byte == 8'hFE) begin
                        bcnt_next = '0;
                        phase_next = sdspi_pkg::PH_RDATA;
                        res.transfer_valid = 1'b1;
                        res.select_card    = 1'b1;
                    end else begin
                        poll_next = poll_inc;
                        if (poll_inc >= tok_e) begin
                            do_fin = 1'b1; fcode = sdspi_pkg::STS_TOKEN;
                            res.transfer_byte = 8'h00;
                        end else begin
                            res.transfer_valid = 1'b1;
                            res.select_card    = 1'b1;
                        end
                    end
                end
                sdspi_pkg::PH_RDATA: begin
                    res.sector_byte_valid = 1'b1;
                    res.sector_byte       = s_card_byte;
                    res.transfer_valid    = 1'b1;
                    res.transfer_byte     = 8'hFF;
                    res.select_card       = 1'b1;
                    bcnt_next = bcnt_inc;
                    if ({1'b0, bcnt_inc} >= 11'(sdspi_pkg::SectorBytes)) begin
                        bcnt_next = '0;
                        phase_next = sdspi_pkg::PH_RCRC;
                    end
                end
                sdspi_pkg::PH_RCRC: begin
                    bcnt_next = bcnt_inc;
                    res.transfer_valid = 1'b1;
                    res.transfer_byte  = 8'hFF;
                    if (bcnt_inc < 10'd2) res.select_card = 1'b1;
                    else phase_next = sdspi_pkg::PH_END;
                end
                sdspi_pkg::PH_WTOKEN: begin
                    bcnt_next = '0;
                    phase_next = sdspi_pkg::PH_WNEED;
                    res.want_write_byte = 1'b1;
                end
                sdspi_pkg::PH_WDATA: begin
                    bcnt_next = bcnt_inc;
                    if ({1'b0, bcnt_inc} < 11'(sdspi_pkg::SectorBytes)) begin
                        phase_next = sdspi_pkg::PH_WNEED;
                        res.want_write_byte = 1'b1;
                    end else begin
                        bcnt_next = '0;
                        phase_next = sdspi_pkg::PH_WCRC;
                        res.transfer_valid = 1'b1;
                        res.transfer_byte  = 8'hFF;
                        res.select_card    = 1'b1;
                    end
                end
                sdspi_pkg::PH_WCRC: begin
                    bcnt_next = bcnt_inc;
                    res.transfer_valid = 1'b1;
                    res.transfer_byte  = 8'hFF;
                    res.select_card    = 1'b1;
                    if (bcnt_inc >= 10'd2) begin
                        poll_next = '0;
                        phase_next = sdspi_pkg::PH_DRESP;
                    end
                end
                sdspi_pkg::PH_DRESP: begin
                    if (s_card_byte[4:0] == 5'h05) begin
                        poll_next = '0;
                        phase_next = sdspi_pkg::PH_BUSY;
                        res.transfer_valid = 1'b1;
                        res.transfer_byte  = 8'hFF;
                        res.select_card    = 1'b1;
                    end else begin
                        poll_next = poll_inc;
                        if (poll_inc >= {12'd0, dresp_e}) begin
                            do_fin = 1'b1; fcode = sdspi_pkg::STS_DRESP;
                        end else begin
                            res.transfer_valid = 1'b1;
                            res.transfer_byte  = 8'hFF;
                            res.select_card    = 1'b1;
                        end
                    end
                end
                sdspi_pkg::PH_BUSY: begin
                    if (s_card_byte != 8'h00) begin
                        phase_next = sdspi_pkg::PH_END;
                        res.transfer_valid = 1'b1;
                        res.transfer_byte  = 8'hFF;
                    end else begin
                        poll_next = poll_inc;
                        if (poll_inc >= busy_e) begin
                            do_fin = 1'b1; fcode = sdspi_pkg::STS_BUSY;
                        end else begin
                            res.transfer_valid = 1'b1;
                            res.transfer_byte  = 8'hFF;
                            res.select_card    = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end else if (s_kind == sdspi_pkg::KIND_WDATA) begin
            if (phase_reg == sdspi_pkg::PH_WNEED) begin
                phase_next = sdspi_pkg::PH_WDATA;
                res.transfer_valid = 1'b1;
                res.transfer_byte  = s_write_byte;
                res.select_card    = 1'b1;
            end
        end

        if (do_after_r1) begin
            res.transfer_valid = 1'b1;
            res.transfer_byte  = 8'hFF;
            res.select_card    = 1'b1;
            if (stage_reg == sdspi_pkg::ST_CMD17) begin
                if (r != 8'h00) begin
                    do_fin = 1'b1; fcode = sdspi_pkg::STS_CMD17; res.transfer_valid = 1'b0;
                end else begin
                    poll_next = '0; phase_next = sdspi_pkg::PH_TOKEN;
                end
            end else if (stage_reg == sdspi_pkg::ST_CMD24) begin
                if (r != 8'h00) begin
                    do_fin = 1'b1; fcode = sdspi_pkg::STS_CMD24; res.transfer_valid = 1'b0;
                end else begin
                    phase_next = sdspi_pkg::PH_WTOKEN; res.transfer_byte = 8'hFE;
                end
            end else if (rest_len != 3'd0) begin
                phase_next = sdspi_pkg::PH_REST; bcnt_next = '0; resp_next = '0;
            end else begin
                phase_next = sdspi_pkg::PH_END; res.select_card = 1'b0;
            end
        end

        // Bump the attempt count, then give up or resend
        if (do_retry) begin
            retry_next = retry_inc;
            if (retry_inc >= rlim) begin
                do_fin = 1'b1; fcode = rcode;
            end else begin
                do_start = 1'b1; nst = rst_st;
            end
        end

        if (do_start) begin
            stage_next = nst;
            phase_next = sdspi_pkg::PH_SEND;
            bcnt_next  = '0;
            res.transfer_valid = 1'b1;
            res.transfer_byte  = sdspi_pkg::frame_byte(nst, 3'd0, addr_next);
            res.select_card    = 1'b1;
        end

        if (do_fin) begin
            phase_next = sdspi_pkg::PH_IDLE;
            res.transfer_valid = 1'b0;
            res.transfer_byte  = 8'h00;
            res.select_card    = 1'b0;
            res.done_res = 1'b1;
            res.status   = fcode;
        end

        res.card_is_standard_out = std_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= sdspi_pkg::PH_IDLE;
            stage_reg  <= sdspi_pkg::ST_CMD0;
            std_reg    <= 1'b0;
            retry_reg  <= '0;
            poll_reg   <= '0;
            bcnt_reg   <= '0;
            addr_reg   <= '0;
            r1_reg     <= 8'hFF;
            resp_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg <= phase_next;
                stage_reg <= stage_next;
                std_reg   <= std_next;
                retry_reg <= retry_next;
                poll_reg  <= poll_next;
                bcnt_reg  <= bcnt_next;
                addr_reg  <= addr_next;
                r1_reg    <= r1_next;
                resp_reg  <= resp_next;
            end
            if (accept) mvalid_reg <= 1'b1;
            else if (m_ready) mvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) res_reg <= res;
    end

    assign m_valid                = mvalid_reg;
    assign m_transfer_valid       = res_reg.transfer_valid;
    assign m_transfer_byte        = res_reg.transfer_byte;
    assign m_select_card          = res_reg.select_card;
    assign m_sector_byte_valid    = res_reg.sector_byte_valid;
    assign m_sector_byte          = res_reg.sector_byte;
    assign m_want_write_byte      = res_reg.want_write_byte;
    assign m_done_res             = res_reg.done_res;
    assign m_status               = res_reg.status;
    assign m_card_is_standard_out = res_reg.card_is_standard_out;
endmodule

### hw/rtl/sdspi_checker.sv
// Port-level checker for the SD card SPI host sequencer
`include "assert_macros.svh"
module sdspi_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_transfer_valid,
    input logic       m_select_card,
    input logic       m_done_res,
    input logic [3:0] m_status,
    input logic       m_want_write_byte
);
    `ASSERT_IMPL(a_status_only_done, aclk, aresetn, m_valid && !m_done_res, m_status == sdspi_pkg::STS_OK, "status set without done")
    `ASSERT_IMPL(a_sel_needs_xfer, aclk, aresetn, m_valid && m_select_card, m_transfer_valid, "select without transfer")
    `ASSERT_IMPL(a_done_no_xfer, aclk, aresetn, m_valid && m_done_res, !m_transfer_valid && !m_want_write_byte, "done with transfer")
    `ASSERT_NEXT(a_accept_gives_out, aclk, aresetn, s_valid && s_ready, m_valid, "accepted word gave no result")
    `ASSERT_IMPL(a_ready_when_free, aclk, aresetn, !m_valid || m_ready, s_ready, "ready low while output free")
endmodule

bind sd_card_spi_host_sequencer sdspi_checker u_sdspi_checker (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .m_transfer_valid,
    .m_select_card, .m_done_res, .m_status, .m_want_write_byte
);

### test/tb.sv
// Testbench for the SD card SPI host sequencer: predicted results checked word by word
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sdspi_pkg::*;

    localparam logic [2:0] KIND_SPARE = 3'd5;  // kinds 5 to 7 are ignored
    localparam int unsigned STALL_LIMIT = 5000;

    typedef struct {
        logic [2:0]  kind;
        logic [31:0] sector;
        logic [7:0]  card_byte;
        logic [7:0]  write_byte;
    } request_word_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [23:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [2:0] s_kind = '0;
    logic [31:0] s_sector = '0;
    logic [7:0] s_card_byte = '0;
    logic [7:0] s_write_byte = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    result_t got;

    sd_card_spi_host_sequencer uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind), .s_sector(s_sector),
        .s_card_byte(s_card_byte), .s_write_byte(s_write_byte),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_transfer_valid(got.transfer_valid), .m_transfer_byte(got.transfer_byte),
        .m_select_card(got.select_card), .m_sector_byte_valid(got.sector_byte_valid),
        .m_sector_byte(got.sector_byte), .m_want_write_byte(got.want_write_byte),
        .m_done_res(got.done_res), .m_status(got.status),
        .m_card_is_standard_out(got.card_is_standard_out)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    request_word_t pending_words[$];
    result_t expected_results[$];
    int errors = 0;
    int words_queued = 0;
    bit quiet = 1'b0;

    // sequencer shadow state
    phase_t      ph;
    stage_t      stg;
    logic        std_cap;
    logic [11:0] retries;
    logic [23:0] polls;
    logic [9:0]  nbytes;
    logic [31:0] cmd_addr;
    logic [7:0]  r1_byte;
    logic [31:0] resp_word;
    logic [7:0]  r1_lim;
    logic [11:0] cmd_lim, app_lim, dresp_lim;
    logic [23:0] token_lim, busy_lim;
    result_t     res;

    function automatic void send_byte(logic [7:0] b, logic sel);
        res.transfer_valid = 1'b1;
        res.transfer_byte = b;
        res.select_card = sel;
    endfunction

    function automatic void end_op(status_t code);
        ph = PH_IDLE;
        res.done_res = 1'b1;
        res.status = code;
    endfunction

    function automatic logic [7:0] cmd_byte(int idx);
        logic [31:0] arg;
        logic [7:0] crc;
        logic [5:0] num;
        arg = '0;
        crc = '0;
        case (stg)
            ST_CMD0: begin num = 6'd0; crc = 8'h95; end
            ST_CMD8: begin num = 6'd8; arg = 32'h1AA; crc = 8'h87; end
            ST_OCR1, ST_OCR2: num = 6'd58;
            ST_CMD55: num = 6'd55;
            ST_ACMD41: begin num = 6'd41; arg = 32'h4000_0000; end
            ST_CMD16: begin num = 6'd16; arg = SectorBytes; end
            ST_CMD17: begin num = 6'd17; arg = cmd_addr; end
            ST_CMD24: begin num = 6'd24; arg = cmd_addr; end
            default: num = 6'd13;
        endcase
        case (idx)
            0: return {2'b01, num};
            1: return arg[31:24];
            2: return arg[23:16];
            3: return arg[15:8];
            4: return arg[7:0];
            default: return crc;
        endcase
    endfunction

    function automatic int tail_len();
        if (stg == ST_CMD8 || stg == ST_OCR1 || stg == ST_OCR2) return 4;
        if (stg == ST_CMD13) return 1;
        return 0;
    endfunction

    function automatic void begin_cmd(stage_t s);
        stg = s;
        ph = PH_SEND;
        nbytes = 0;
        send_byte(cmd_byte(0), 1'b1);
    endfunction

    function automatic void retry_or_fail(logic [11:0] lim, status_t code, stage_t s);
        retries = retries + 12'd1;
        if (retries >= lim) end_op(code);
        else begin_cmd(s);
    endfunction

    function automatic void r1_done();
        if (stg == ST_CMD17) begin
            if (r1_byte != 0) begin end_op(STS_CMD17); return; end
            polls = 0;
            ph = PH_TOKEN;
            send_byte(8'hFF, 1'b1);
        end else if (stg == ST_CMD24) begin
            if (r1_byte != 0) begin end_op(STS_CMD24); return; end
            ph = PH_WTOKEN;
            send_byte(8'hFE, 1'b1);
        end else if (tail_len() > 0) begin
            ph = PH_REST;
            nbytes = 0;
            resp_word = 0;
            send_byte(8'hFF, 1'b1);
        end else begin
            ph = PH_END;
            send_byte(8'hFF, 1'b0);
        end
    endfunction

    function automatic void command_closed();
        case (stg)
            ST_CMD0:
                if (r1_byte == 8'h01) begin retries = 0; begin_cmd(ST_CMD8); end
                else retry_or_fail(cmd_lim, STS_CMD0, ST_CMD0);
            ST_CMD8:
                if (r1_byte == 8'h09) end_op(STS_CMD8_V1);
                else if (r1_byte == 8'h01 && resp_word[11:8] == 4'h1 &&
                         resp_word[7:0] == 8'hAA) begin
                    retries = 0;
                    begin_cmd(ST_OCR1);
                end else end_op(STS_CMD8_BAD);
            ST_OCR1:
                if (r1_byte == 8'h01 && resp_word[20:16] != 0 && resp_word[15]) begin
                    retries = 0;
                    begin_cmd(ST_CMD55);
                end else retry_or_fail(cmd_lim, STS_OCR1, ST_OCR1);
            ST_CMD55:
                if (r1_byte != 8'h01) end_op(STS_CMD55);
                else begin_cmd(ST_ACMD41);
            ST_ACMD41:
                if (r1_byte == 0) begin retries = 0; begin_cmd(ST_OCR2); end
                else retry_or_fail(app_lim, STS_ACMD41, ST_CMD55);
            ST_OCR2:
                if (r1_byte == 0) begin
                    if (resp_word[30]) begin
                        std_cap = 1'b0;
                        end_op(STS_OK);
                    end else begin
                        retries = 0;
                        begin_cmd(ST_CMD16);
                    end
                end else retry_or_fail(cmd_lim, STS_OCR2, ST_OCR2);
            ST_CMD16:
                if (r1_byte == 0) begin std_cap = 1'b1; end_op(STS_OK); end
                else retry_or_fail(cmd_lim, STS_CMD16, ST_CMD16);
            ST_CMD24: begin_cmd(ST_CMD13);
            ST_CMD13:
                end_op((r1_byte == 0 && resp_word[7:0] == 0) ? STS_OK : STS_CMD13);
            default: end_op(STS_OK);
        endcase
    endfunction

    function automatic void take_card_byte(logic [7:0] b);
        case (ph)
            PH_DUMMY: begin
                nbytes++;
                if (nbytes < DummyBytes) send_byte(8'hFF, 1'b0);
                else begin retries = 0; begin_cmd(ST_CMD0); end
            end
            PH_SEND: begin
                nbytes++;
                if (nbytes < 6) send_byte(cmd_byte(nbytes), 1'b1);
                else begin polls = 0; ph = PH_R1; send_byte(8'hFF, 1'b1); end
            end
            PH_R1:
                if (b != 8'hFF) begin
                    r1_byte = b;
                    r1_done();
                end else begin
                    polls++;
                    if (polls >= r1_lim) begin r1_byte = 8'hFF; r1_done(); end
                    else send_byte(8'hFF, 1'b1);
                end
            PH_REST: begin
                resp_word = {resp_word[23:0], b};
                nbytes++;
                if (nbytes < tail_len()) send_byte(8'hFF, 1'b1);
                else begin ph = PH_END; send_byte(8'hFF, 1'b0); end
            end
            PH_END: command_closed();
            PH_TOKEN:
                if (b == 8'hFE) begin
                    nbytes = 0;
                    ph = PH_RDATA;
                    send_byte(8'hFF, 1'b1);
                end else begin
                    polls++;
                    if (polls >= token_lim) end_op(STS_TOKEN);
                    else send_byte(8'hFF, 1'b1);
                end
            PH_RDATA: begin
                res.sector_byte_valid = 1'b1;
                res.sector_byte = b;
                nbytes++;
                if (nbytes >= SectorBytes) begin nbytes = 0; ph = PH_RCRC; end
                send_byte(8'hFF, 1'b1);
            end
            PH_RCRC: begin
                nbytes++;
                if (nbytes < 2) send_byte(8'hFF, 1'b1);
                else begin ph = PH_END; send_byte(8'hFF, 1'b0); end
            end
            PH_WTOKEN: begin
                nbytes = 0;
                ph = PH_WNEED;
                res.want_write_byte = 1'b1;
            end
            PH_WDATA: begin
                nbytes++;
                if (nbytes < SectorBytes) begin
                    ph = PH_WNEED;
                    res.want_write_byte = 1'b1;
                end else begin
                    nbytes = 0;
                    ph = PH_WCRC;
                    send_byte(8'hFF, 1'b1);
                end
            end
            PH_WCRC: begin
                nbytes++;
                if (nbytes < 2) send_byte(8'hFF, 1'b1);
                else begin polls = 0; ph = PH_DRESP; send_byte(8'hFF, 1'b1); end
            end
            PH_DRESP:
                if (b[4:0] == 5'h05) begin
                    polls = 0;
                    ph = PH_BUSY;
                    send_byte(8'hFF, 1'b1);
                end else begin
                    polls++;
                    if (polls >= dresp_lim) end_op(STS_DRESP);
                    else send_byte(8'hFF, 1'b1);
                end
            PH_BUSY:
                if (b != 0) begin
                    ph = PH_END;
                    send_byte(8'hFF, 1'b0);
                end else begin
                    polls++;
                    if (polls >= busy_lim) end_op(STS_BUSY);
                    else send_byte(8'hFF, 1'b1);
                end
            default: ;
        endcase
    endfunction

    function automatic result_t sequencer_step(request_word_t w);
        res = '0;
        if (w.kind <= KIND_WRITE) begin
            if (ph != PH_IDLE) begin
                res.done_res = 1'b1;
                res.status = STS_BUSY_REQ;
            end else if (w.kind == KIND_INIT) begin
                retries = 0;
                nbytes = 0;
                ph = PH_DUMMY;
                send_byte(8'hFF, 1'b0);
            end else begin
                cmd_addr = std_cap ? (w.sector << 9) : w.sector;
                begin_cmd(w.kind == KIND_READ ? ST_CMD17 : ST_CMD24);
            end
        end else if (w.kind == KIND_CARD) begin
            if (ph != PH_IDLE && ph != PH_WNEED) take_card_byte(w.card_byte);
        end else if (w.kind == KIND_WDATA) begin
            if (ph == PH_WNEED) begin
                ph = PH_WDATA;
                send_byte(w.write_byte, 1'b1);
            end
        end
        res.card_is_standard_out = std_cap;
        return res;
    endfunction

    // card reply that mostly lets the sequence move on, sometimes not
    function automatic logic [7:0] card_reply();
        int pick;
        pick = $urandom_range(0, 99);
        case (ph)
            PH_R1: begin
                if (pick < 10) return 8'hFF;
                if (pick < 18) return 8'($urandom);
                if (stg == ST_CMD8 && pick < 22) return 8'h09;
                case (stg)
                    ST_CMD0, ST_CMD8, ST_OCR1, ST_CMD55: return 8'h01;
                    ST_ACMD41: return (pick < 60) ? 8'h01 : 8'h00;
                    default: return 8'h00;
                endcase
            end
            PH_REST: begin
                if (pick < 8) return 8'($urandom);
                if (stg == ST_CMD8) return (nbytes == 2) ? 8'h01 : (nbytes == 3) ? 8'hAA : 8'h00;
                if (stg == ST_CMD13) return 8'h00;
                case (nbytes)
                    10'd1: return 8'h1F | 8'($urandom);
                    10'd2: return 8'h80 | 8'($urandom);
                    default: return 8'($urandom);
                endcase
            end
            PH_TOKEN: return (pick < 30) ? 8'hFE : (pick < 90) ? 8'hFF : 8'($urandom);
            PH_DRESP: return (pick < 40) ? {3'($urandom), 5'h05} : 8'($urandom);
            PH_BUSY: return (pick < 40) ? 8'($urandom) | 8'h01 : 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic queue_word(logic [2:0] kind, logic [31:0] sector);
        request_word_t w;
        w.kind = kind;
        w.sector = sector;
        w.card_byte = card_reply();
        w.write_byte = 8'($urandom);
        expected_results.push_back(sequencer_step(w));
        pending_words.push_back(w);
        words_queued++;
    endtask

    task automatic queue_noise();
        case ($urandom_range(0, 3))
            0: queue_word(3'($urandom_range(KIND_INIT, KIND_WRITE)), $urandom);
            1: queue_word(KIND_SPARE + 3'($urandom_range(0, 2)), $urandom);
            2: queue_word(KIND_WDATA, $urandom);
            default: queue_word(KIND_CARD, $urandom);
        endcase
    endtask

    // one request, then the card and host words it calls for, with stray words mixed in, until done
    task automatic run_request(logic [2:0] kind, logic [31:0] sector);
        queue_word(kind, sector);
        while (ph != PH_IDLE) begin
            if ($urandom_range(0, 99) < 3) queue_noise();
            else if (ph == PH_WNEED) queue_word(KIND_WDATA, $urandom);
            else queue_word(KIND_CARD, $urandom);
        end
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [23:0] value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            CFG_R1_POLL: r1_lim = value[7:0];
            CFG_CMD_RETRY: cmd_lim = value[11:0];
            CFG_APP_RETRY: app_lim = value[11:0];
            CFG_TOKEN_WAIT: token_lim = value;
            CFG_DRESP_WAIT: dresp_lim = value[11:0];
            default: busy_lim = value;
        endcase
    endtask

    task automatic set_limits(logic [7:0] r1, logic [11:0] cmd, logic [11:0] app,
                              logic [23:0] tok, logic [11:0] dr, logic [23:0] bsy);
        wait (pending_words.size() == 0 && expected_results.size() == 0);
        repeat (4) @(posedge aclk);
        write_reg(CFG_R1_POLL, r1);
        write_reg(CFG_CMD_RETRY, cmd);
        write_reg(CFG_APP_RETRY, app);
        write_reg(CFG_TOKEN_WAIT, tok);
        write_reg(CFG_DRESP_WAIT, dr);
        write_reg(CFG_BUSY_WAIT, bsy);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // init sequences mixed with stray words while idle
    task automatic random_requests(int target);
        int start;
        start = words_queued;
        while (words_queued - start < target) begin
            if ($urandom_range(0, 4) == 0) queue_word(KIND_CARD + 3'($urandom_range(0, 4)), $urandom);
            else run_request(KIND_INIT, $urandom);
        end
    endtask

    int idle_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            idle_left <= 0;
        end else if (!(s_valid && !s_ready)) begin
            if (idle_left > 0) begin
                idle_left <= idle_left - 1;
                s_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                // hold s_valid low for a random idle burst
                idle_left <= $urandom_range(0, 6);
                s_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                s_kind <= pending_words[0].kind;
                s_sector <= pending_words[0].sector;
                s_card_byte <= pending_words[0].card_byte;
                s_write_byte <= pending_words[0].write_byte;
                void'(pending_words.pop_front());
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    function automatic void check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s expected %0h got %0h", $realtime, name, exp_v, act_v);
            errors++;
        end
    endfunction

    int stall_left = 0;
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected word, expected none got %h", $realtime, got);
                errors++;
            end else begin
                want = expected_results.pop_front();
                check_field("transfer_valid", want.transfer_valid, got.transfer_valid);
                check_field("transfer_byte", want.transfer_byte, got.transfer_byte);
                check_field("select_card", want.select_card, got.select_card);
                check_field("sector_byte_valid", want.sector_byte_valid,
                            got.sector_byte_valid);
                check_field("sector_byte", want.sector_byte, got.sector_byte);
                check_field("want_write_byte", want.want_write_byte, got.want_write_byte);
                check_field("done_res", want.done_res, got.done_res);
                check_field("status", want.status, got.status);
                check_field("card_is_standard_out", want.card_is_standard_out,
                            got.card_is_standard_out);
            end
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 6);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("sd_card_spi_host_sequencer verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        ph = PH_IDLE;
        stg = ST_CMD0;
        std_cap = 1'b0;
        retries = 0;
        polls = 0;
        nbytes = 0;
        cmd_addr = 0;
        r1_byte = 8'hFF;
        resp_word = 0;
        r1_lim = 8'd255;
        cmd_lim = 12'd254;
        app_lim = 12'd4094;
        token_lim = 24'd16777214;
        dresp_lim = 12'd4094;
        busy_lim = 24'd16777214;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: stray words while idle, then init and a full sector read
        queue_word(KIND_CARD, 32'h0);
        queue_word(KIND_WDATA, 32'h0);
        queue_word(KIND_SPARE, 32'hFFFF_FFFF);
        queue_word(KIND_SPARE + 3'd1, 32'h0);
        queue_word(KIND_SPARE + 3'd2, 32'h0);
        run_request(KIND_INIT, 32'h0);
        run_request(KIND_READ, 32'hFFFF_FFFF);

        set_limits(8'd1, 12'd1, 12'd1, 24'd1, 12'd1, 24'd1);
        random_requests(40);
        // short limits on every poll and retry around a sector write
        set_limits(8'd3, 12'd2, 12'd5, 24'd4, 12'd3, 24'd6);
        run_request(KIND_WRITE, 32'h0);
        random_requests(40);
        set_limits(8'($urandom_range(1, 255)), 12'($urandom_range(1, 20)),
                   12'($urandom_range(1, 20)), 24'($urandom_range(1, 50)),
                   12'($urandom_range(1, 20)), 24'($urandom_range(1, 50)));
        quiet = 1'b1;
        random_requests(40);

        wait (pending_words.size() == 0 && expected_results.size() == 0);
        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("sd_card_spi_host_sequencer verification clean");
        end else begin
            $display("sd_card_spi_host_sequencer verification failed");
        end
        $finish;
    end
endmodule

### sd_card_spi_host_sequencer.f
+incdir+hw/rtl
hw/rtl/sdspi_pkg.sv
hw/rtl/sdspi_cfg_regs.sv
hw/rtl/sd_card_spi_host_sequencer.sv
hw/rtl/sdspi_checker.sv
test/tb.sv
